@@ rtl/olad_pkg.sv @@
// ----------------------------------------------------------------------------
// olad_pkg
// Shared types and codes for the ordered list with append and delete.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef logic [CMD_W-1:0]    cmd_code_t;
  typedef logic [STATUS_W-1:0] status_code_t;

  localparam cmd_code_t CMD_APPEND = 2'd0;
  localparam cmd_code_t CMD_DELETE = 2'd1;
  localparam cmd_code_t CMD_DUMP   = 2'd2;

  localparam status_code_t ST_APPENDED  = 3'd0;
  localparam status_code_t ST_DELETED   = 3'd1;
  localparam status_code_t ST_NOT_FOUND = 3'd2;
  localparam status_code_t ST_FULL      = 3'd3;
  localparam status_code_t ST_DUMP      = 3'd4;
  localparam status_code_t ST_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    PTR_HOLD  = 2'd0,
    PTR_CLEAR = 2'd1,
    PTR_INC   = 2'd2
  } ptr_op_t;

  typedef struct packed {
    logic         ld_value;
    ptr_op_t      ptr_op;
    logic         wr_append;
    logic         wr_shift;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         out_load;
    logic         out_dump;
    logic         out_last;
    status_code_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic ptr_last;
    logic ptr_below;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/olad_ctrl.sv @@
// ----------------------------------------------------------------------------
// olad_ctrl
// Sequencer that walks the list for delete and dump and issues datapath commands.
// ----------------------------------------------------------------------------
module olad_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  olad_pkg::cmd_code_t in_command,
  input  olad_pkg::dp_stat_t  stat,
  output olad_pkg::dp_cmd_t   cmd
);
  import olad_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_DUMP   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  status_code_t resp_r, resp_nxt;
  logic         accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    resp_nxt       = resp_r;
    cmd            = '0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.out_status = ST_DUMP;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_value = 1'b1;
          cmd.ptr_op   = PTR_CLEAR;
          case (in_command)
            CMD_APPEND: begin
              if (stat.full) begin
                resp_nxt = ST_FULL;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.cnt_inc   = 1'b1;
                resp_nxt      = ST_APPENDED;
              end
              state_nxt = S_RESP;
            end
            CMD_DELETE: begin
              if (stat.empty) begin
                resp_nxt  = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            CMD_DUMP: begin
              if (stat.empty) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (stat.match) begin
          cmd.ptr_op = PTR_INC;
          state_nxt  = S_SHIFT;
        end else if (stat.ptr_last) begin
          resp_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_SHIFT: begin
        if (stat.ptr_below) begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_op   = PTR_INC;
        end else begin
          cmd.cnt_dec = 1'b1;
          resp_nxt    = ST_DELETED;
          state_nxt   = S_RESP;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_dump   = 1'b1;
          cmd.out_last   = stat.ptr_last;
          cmd.out_status = ST_DUMP;
          if (stat.ptr_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = resp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    resp_r <= resp_nxt;
  end

endmodule

@@ rtl/olad_dp.sv @@
// ----------------------------------------------------------------------------
// olad_dp
// Entry memory, fill count, walk pointer, compare and output register.
// ----------------------------------------------------------------------------
module olad_dp #(
  parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [olad_pkg::VALUE_W-1:0]    in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output olad_pkg::status_code_t                 out_status,
  output logic signed [olad_pkg::VALUE_W-1:0]    out_entry_value,
  output logic        [olad_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                                   out_last,
  input  olad_pkg::dp_cmd_t                      cmd,
  output olad_pkg::dp_stat_t                     stat
);
  import olad_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          ptr_r, ptr_nxt;
  logic [CNT_W-1:0]          ptr_prev;
  logic [CNT_W-1:0]          ptr_inc;

  logic                      out_valid_r;
  status_code_t              out_status_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_last_r;

  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign ptr_prev = ptr_r - CNT_W'(1);

  always_comb begin
    case (cmd.ptr_op)
      PTR_CLEAR: ptr_nxt = '0;
      PTR_INC:   ptr_nxt = ptr_inc;
      default:   ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_append) begin
      mem[count_r[AW-1:0]] <= in_value;
    end
    if (cmd.wr_shift) begin
      mem[ptr_prev[AW-1:0]] <= rd_data_r;
    end
    rd_data_r <= mem[ptr_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    ptr_r <= ptr_nxt;
    if (cmd.ld_value) begin
      value_r <= in_value;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_value_r  <= cmd.out_dump ? rd_data_r : '0;
      out_count_r  <= COUNT_W'(count_r);
      out_last_r   <= cmd.out_last;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_W'(CAPACITY));
  assign stat.match     = (rd_data_r == value_r);
  assign stat.ptr_last  = (ptr_inc == count_r);
  assign stat.ptr_below = (ptr_r < count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

@@ rtl/ordered_list_append_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Bounded ordered list of signed 32-bit values with append, delete and dump.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY values in a single-port-read memory, head at
// address zero. An append gives one item. A delete scans from the head for the
// first match and then moves each later entry one place toward the head, one
// memory access per cycle, and gives one item. A dump reads one entry per cycle
// while the output register is free and gives one item per entry, the final one
// marked last, or a single empty item for an empty list. The memory's one read
// port is why entries are read one at a time. A new command is taken only once
// the previous one has handed its last item to the output register.
module ordered_list_append_delete #(
  parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [olad_pkg::CMD_W-1:0]   in_command,
  input  logic signed [olad_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [olad_pkg::STATUS_W-1:0] out_status,
  output logic signed [olad_pkg::VALUE_W-1:0] out_entry_value,
  output logic        [olad_pkg::COUNT_W-1:0] out_entry_count,
  output logic                                out_last
);
  import olad_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  olad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  olad_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last),
    .cmd             (dp_cmd),
    .stat            (dp_stat)
  );

endmodule
